// File: sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // Input action codes
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_BYTE  = 2'd1;
   localparam logic [1:0] ACT_END   = 2'd2;

   // Characters of interest
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   // Surrogate bounds
   localparam logic [15:0] HI_SURR_MIN = 16'hD800;
   localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
   localparam logic [31:0] LO_SURR_BASE = 32'h0000_DC00;
   localparam logic [31:0] HI_SURR_BASE = 32'h0000_D800;
   localparam logic [31:0] SUPP_BASE    = 32'h0001_0000;

   // UTF-8 length boundaries
   localparam logic [20:0] CP_MAX_1 = 21'h00007F;
   localparam logic [20:0] CP_MAX_2 = 21'h0007FF;
   localparam logic [20:0] CP_MAX_3 = 21'h00FFFF;

   // Default depth of the job queue between front and back
   localparam int JOB_DEPTH_DEF = 4;

   // Decoder mode, one-hot
   typedef enum logic [7:0] {
      M_IDLE   = 8'b0000_0001,
      M_BODY   = 8'b0000_0010,
      M_ESC    = 8'b0000_0100,
      M_HEXHI  = 8'b0000_1000,
      M_WAITBS = 8'b0001_0000,
      M_WAITU  = 8'b0010_0000,
      M_HEXLO  = 8'b0100_0000,
      M_CLOSED = 8'b1000_0000
   } mode_type;

   // One job: a code point's bytes, then an optional single result, then
   // an optional end-of-text status result.
   typedef struct packed {
      logic [20:0] cp;
      logic [2:0]  ncp;        // bytes of cp to emit, 0 when none
      logic        tail_en;
      logic [7:0]  tail_data;
      logic        tail_has;
      logic        tail_closed;
      logic        stat_en;
      logic        err;        // error flag for cp and tail results
      logic [2:0]  total;      // results in this job
   } job_type;

   // Hex digit decode: {ok, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'b0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   // Simple escape translation; unknown characters pass through
   function automatic logic [7:0] esc_char(input logic [7:0] e);
      logic [7:0] v;
      case (e)
         8'h6E:   v = 8'h0A; // n
         8'h72:   v = 8'h0D; // r
         8'h74:   v = 8'h09; // t
         8'h62:   v = 8'h08; // b
         8'h66:   v = 8'h0C; // f
         default: v = e;
      endcase
      return v;
   endfunction

   // Surrogate pair join; the result is truncated to 21 bits
   function automatic logic [20:0] join_units(input logic [15:0] hi,
                                              input logic [15:0] lo);
      logic [31:0] s;
      s = SUPP_BASE + (({16'b0, hi} - HI_SURR_BASE) << 10)
          + ({16'b0, lo} - LO_SURR_BASE);
      return s[20:0];
   endfunction

   // Number of UTF-8 bytes for a code point
   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] n;
      if (cp <= CP_MAX_1)      n = 3'd1;
      else if (cp <= CP_MAX_2) n = 3'd2;
      else if (cp <= CP_MAX_3) n = 3'd3;
      else                     n = 3'd4;
      return n;
   endfunction

   // Byte idx of the n-byte UTF-8 form of cp
   function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                            input logic [2:0]  n,
                                            input logic [1:0]  idx);
      logic [7:0] r;
      r = 8'h00;
      case (n)
         3'd1: r = cp[7:0];
         3'd2: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         3'd3: begin
            case (idx)
               2'd0:    r = {4'b1110, cp[15:12]};
               2'd1:    r = {2'b10, cp[11:6]};
               default: r = {2'b10, cp[5:0]};
            endcase
         end
         3'd4: begin
            case (idx)
               2'd0:    r = {5'b11110, cp[20:18]};
               2'd1:    r = {2'b10, cp[17:12]};
               2'd2:    r = {2'b10, cp[11:6]};
               default: r = {2'b10, cp[5:0]};
            endcase
         end
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// File: sv/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_if
// Valid/ready channel interfaces for text input and decoded output.
// ----------------------------------------------------------------------------
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] text_byte;

   modport source (output valid, action, text_byte, input ready);
   modport sink   (input valid, action, text_byte, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   logic       has_data;
   logic       closed;
   logic       error;
   logic       last;

   modport source (output valid, data, has_data, closed, error, last, input ready);
   modport sink   (input valid, data, has_data, closed, error, last, output ready);
endinterface

// File: sv/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Takes input transactions, runs the escape/hex state machine and turns
// each transaction into at most one output job.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   jsu_req_if.sink       req_chan,
   input  logic          job_full,
   output logic          job_push,
   output job_type       job
);

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] hex_value_ff, hex_value_in;
   logic [15:0] high_unit_ff, high_unit_in;
   logic        error_ff, error_in;

   logic        accept;
   logic [4:0]  dig;
   logic [15:0] hex_shift;
   logic        is_quote, is_bs;
   job_type     job_c;

   assign req_chan.ready = !job_full;
   assign accept         = req_chan.valid && req_chan.ready;

   assign dig       = hex_digit(req_chan.text_byte);
   assign hex_shift = {hex_value_ff[11:0], dig[3:0]};
   assign is_quote  = (req_chan.text_byte == CH_QUOTE);
   assign is_bs     = (req_chan.text_byte == CH_BSLASH);

   // Next state and job classification
   always_comb begin
      mode_in      = mode_ff;
      hex_count_in = hex_count_ff;
      hex_value_in = hex_value_ff;
      high_unit_in = high_unit_ff;
      error_in     = error_ff;
      job_c        = '0;
      job_c.err    = error_ff;

      if (req_chan.action == ACT_START) begin
         mode_in      = M_BODY;
         hex_count_in = 2'd0;
         hex_value_in = 16'd0;
         high_unit_in = 16'd0;
      end else if (mode_ff != M_IDLE && mode_ff != M_CLOSED) begin
         if (req_chan.action == ACT_END) begin
            // flush whatever is pending, then a status result
            case (mode_ff)
               M_ESC: begin
                  job_c.tail_en   = 1'b1;
                  job_c.tail_data = CH_BSLASH;
                  job_c.tail_has  = 1'b1;
               end
               M_HEXHI: begin
                  job_c.cp = {5'b0, hex_value_ff};
                  job_c.ncp = utf8_len(job_c.cp);
               end
               M_WAITBS: begin
                  job_c.cp = {5'b0, high_unit_ff};
                  job_c.ncp = utf8_len(job_c.cp);
               end
               M_WAITU: begin
                  job_c.cp        = {5'b0, high_unit_ff};
                  job_c.ncp       = utf8_len(job_c.cp);
                  job_c.tail_en   = 1'b1;
                  job_c.tail_data = CH_BSLASH;
                  job_c.tail_has  = 1'b1;
               end
               M_HEXLO: begin
                  job_c.cp  = join_units(high_unit_ff, hex_value_ff);
                  job_c.ncp = utf8_len(job_c.cp);
               end
               default: ;
            endcase
            job_c.stat_en = 1'b1;
            error_in      = 1'b1;
            mode_in       = M_IDLE;
            hex_count_in  = 2'd0;
         end else if (req_chan.action == ACT_BYTE) begin
            case (mode_ff)
               M_BODY: begin
                  if (is_quote) begin
                     job_c.tail_en     = 1'b1;
                     job_c.tail_closed = 1'b1;
                     mode_in           = M_CLOSED;
                  end else if (is_bs) begin
                     mode_in = M_ESC;
                  end else begin
                     job_c.tail_en   = 1'b1;
                     job_c.tail_data = req_chan.text_byte;
                     job_c.tail_has  = 1'b1;
                  end
               end
               M_ESC: begin
                  if (req_chan.text_byte == CH_U) begin
                     mode_in      = M_HEXHI;
                     hex_count_in = 2'd0;
                     hex_value_in = 16'd0;
                  end else begin
                     job_c.tail_en   = 1'b1;
                     job_c.tail_data = esc_char(req_chan.text_byte);
                     job_c.tail_has  = 1'b1;
                     mode_in         = M_BODY;
                  end
               end
               M_HEXHI, M_HEXLO: begin
                  if (!dig[4]) begin
                     // bad digit: emit NUL (or joined value) and flag error
                     error_in     = 1'b1;
                     job_c.err    = 1'b1;
                     mode_in      = M_BODY;
                     hex_count_in = 2'd0;
                     job_c.cp     = (mode_ff == M_HEXLO) ?
                                    join_units(high_unit_ff, 16'd0) : 21'd0;
                     job_c.ncp    = utf8_len(job_c.cp);
                  end else begin
                     hex_value_in = hex_shift;
                     if (hex_count_ff != 2'd3) begin
                        hex_count_in = hex_count_ff + 2'd1;
                     end else begin
                        hex_count_in = 2'd0;
                        if (mode_ff == M_HEXLO) begin
                           mode_in   = M_BODY;
                           job_c.cp  = join_units(high_unit_ff, hex_shift);
                           job_c.ncp = utf8_len(job_c.cp);
                        end else if (hex_shift >= HI_SURR_MIN &&
                                     hex_shift <= HI_SURR_MAX) begin
                           high_unit_in = hex_shift;
                           mode_in      = M_WAITBS;
                        end else begin
                           mode_in   = M_BODY;
                           job_c.cp  = {5'b0, hex_shift};
                           job_c.ncp = utf8_len(job_c.cp);
                        end
                     end
                  end
               end
               M_WAITBS: begin
                  if (is_bs) begin
                     mode_in = M_WAITU;
                  end else begin
                     // lone high surrogate, then the byte as body text
                     job_c.cp  = {5'b0, high_unit_ff};
                     job_c.ncp = utf8_len(job_c.cp);
                     mode_in   = M_BODY;
                     if (is_quote) begin
                        job_c.tail_en     = 1'b1;
                        job_c.tail_closed = 1'b1;
                        mode_in           = M_CLOSED;
                     end else begin
                        job_c.tail_en   = 1'b1;
                        job_c.tail_data = req_chan.text_byte;
                        job_c.tail_has  = 1'b1;
                     end
                  end
               end
               M_WAITU: begin
                  if (req_chan.text_byte == CH_U) begin
                     mode_in      = M_HEXLO;
                     hex_count_in = 2'd0;
                     hex_value_in = 16'd0;
                  end else begin
                     // lone high surrogate, then a plain escape
                     job_c.cp        = {5'b0, high_unit_ff};
                     job_c.ncp       = utf8_len(job_c.cp);
                     job_c.tail_en   = 1'b1;
                     job_c.tail_data = esc_char(req_chan.text_byte);
                     job_c.tail_has  = 1'b1;
                     mode_in         = M_BODY;
                  end
               end
               default: ;
            endcase
         end
      end
      job_c.total = job_c.ncp + {2'b0, job_c.tail_en} + {2'b0, job_c.stat_en};
   end

   assign job      = job_c;
   assign job_push = accept && (job_c.total != 3'd0);

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_IDLE;
         hex_count_ff <= 2'd0;
         hex_value_ff <= 16'd0;
         high_unit_ff <= 16'd0;
         error_ff     <= 1'b0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         hex_count_ff <= hex_count_in;
         hex_value_ff <= hex_value_in;
         high_unit_ff <= high_unit_in;
         error_ff     <= error_in;
      end
   end

endmodule

// File: sv/jsu_job_fifo.sv
// ----------------------------------------------------------------------------
// jsu_job_fifo
// Small job queue decoupling the front classifier from the byte emitter.
// ----------------------------------------------------------------------------
module jsu_job_fifo import jsu_pkg::*; #(
   parameter int DEPTH = JOB_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = store_ff[rd_ptr_ff];

   // Occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   // Pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Walks the head job into the output register, one result per unstalled cycle.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      job_valid,
   input  job_type   job,
   output logic      job_pop,
   jsu_rsp_if.source rsp_chan
);

   logic [2:0] seq_ff;
   logic       load;
   logic       is_last;

   logic       rsp_valid_ff;
   logic [7:0] data_ff, data_in;
   logic       has_ff, has_in;
   logic       closed_ff, closed_in;
   logic       error_ff, error_in;
   logic       last_ff;

   assign load    = job_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign is_last = (seq_ff == job.total - 3'd1);
   assign job_pop = load && is_last;

   // Select the result at position seq_ff of the head job
   always_comb begin
      data_in   = 8'h00;
      has_in    = 1'b0;
      closed_in = 1'b0;
      error_in  = 1'b1;
      if (seq_ff < job.ncp) begin
         data_in  = utf8_byte(job.cp, job.ncp, seq_ff[1:0]);
         has_in   = 1'b1;
         error_in = job.err;
      end else if (job.tail_en && seq_ff == job.ncp) begin
         data_in   = job.tail_data;
         has_in    = job.tail_has;
         closed_in = job.tail_closed;
         error_in  = job.err;
      end
   end

   // Sequence counter and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            seq_ff       <= is_last ? 3'd0 : seq_ff + 3'd1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff   <= data_in;
         has_ff    <= has_in;
         closed_ff <= closed_in;
         error_ff  <= error_in;
         last_ff   <= is_last;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.data     = data_ff;
   assign rsp_chan.has_data = has_ff;
   assign rsp_chan.closed   = closed_ff;
   assign rsp_chan.error    = error_ff;
   assign rsp_chan.last     = last_ff;

endmodule

// File: sv/json_string_unescaper_core.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_core
// Streaming JSON string-body decoder producing UTF-8 output bytes.
//
//   Channel   Dir  Handshake     Payload
//   req_chan  in   valid/ready   action[1:0], text_byte[7:0]
//   rsp_chan  out  valid/ready   data[7:0], has_data, closed, error, last
//
// An input transaction is taken every cycle while the job queue has room
// (JOB_DEPTH entries). The output register drains one result per cycle
// while rsp_chan.ready allows, so an input yielding k results (0 to 5)
// holds the back end for all k; one-result inputs sustain one per cycle.
// Reset is synchronous; no clearing pass.
// Output stalls back up through the queue into req_chan.ready.
// ----------------------------------------------------------------------------
module json_string_unescaper_core import jsu_pkg::*; #(
   parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);

   logic    job_push, job_pop, job_full, job_valid;
   job_type push_job, head_job;

   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .job_full (job_full),
      .job_push (job_push),
      .job      (push_job)
   );

   jsu_job_fifo #(
      .DEPTH (JOB_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .full      (job_full),
      .not_empty (job_valid),
      .head      (head_job)
   );

   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: sv/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the decoded output stream.
// ----------------------------------------------------------------------------
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data,
   input logic       rsp_has_data,
   input logic       rsp_closed,
   input logic       rsp_error,
   input logic       rsp_last
);

   logic err_seen_ff;

   // Remember that an error has been reported
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_error) begin
         err_seen_ff <= 1'b1;
      end
   end

   // A stalled output transaction holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)
      && $stable(rsp_last) && $stable(rsp_error))
      else $error("rsp payload changed while stalled");

   // Error is sticky across results
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && err_seen_ff |-> rsp_error)
      else $error("error flag dropped");

   // Closing quote result carries no byte and ends its transaction
   a_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closed |-> !rsp_has_data && rsp_last && rsp_data == 8'h00)
      else $error("bad closing result");

   // Results without a byte carry zero data
   a_nodata: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_data |-> rsp_data == 8'h00 && rsp_last)
      else $error("status result malformed");

   // Nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind json_string_unescaper_core jsu_checker u_jsu_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_data     (rsp_chan.data),
   .rsp_has_data (rsp_chan.has_data),
   .rsp_closed   (rsp_chan.closed),
   .rsp_error    (rsp_chan.error),
   .rsp_last     (rsp_chan.last)
);
